[sv/assert_macros.svh]
// Assertion macros used by the sorted list RTL top level.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/dsl_pkg.sv]
`timescale 1ns / 1ps
// Package for the descending sorted list: sizes, codes and the cell command.
// No dependencies; used by dsl_cell, descending_sorted_list_core and the testbench.
package dsl_pkg;

  localparam int unsigned DEPTH    = 16;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned ENTRY_W  = 5;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W    = $clog2(DEPTH);
  localparam int unsigned CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [CNT_W-1:0]         count_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CMP_W-1:0]         cmp_t;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2
  } cell_op_e;

  // Broadcast from the control to every cell of the chain.
  typedef struct packed {
    cell_op_e op;
    word_t    value;
    cmp_t     pos;
    count_t   count;
  } cell_cmd_t;

endpackage

[sv/dsl_cell.sv]
`timescale 1ns / 1ps
// One storage cell of the sorted chain: holds an entry, compares, shifts.
// Depends on dsl_pkg.
module dsl_cell (
  input  logic               clk_i,
  input  dsl_pkg::cell_cmd_t cmd_i,
  input  dsl_pkg::idx_t      idx_i,
  input  dsl_pkg::word_t     left_val_i,
  input  logic               left_ge_i,
  input  dsl_pkg::word_t     right_val_i,
  output dsl_pkg::word_t     val_o,
  output logic               ge_o
);
  import dsl_pkg::*;

  word_t val_q;
  word_t val_d;
  cmp_t  idx_ext;
  logic  occupied;

  assign idx_ext  = cmp_t'(idx_i);
  assign occupied = idx_ext < cmp_t'(cmd_i.count);
  // Entry ranks at or above the new value: it stays put on insert.
  assign ge_o     = occupied && (val_q >= cmd_i.value);
  assign val_o    = val_q;

  always_comb begin
    val_d = val_q;
    case (cmd_i.op)
      CELL_INSERT: begin
        // First cell below the new value takes it; later ones shift down.
        if (!ge_o) begin
          val_d = left_ge_i ? cmd_i.value : left_val_i;
        end
      end
      CELL_REMOVE: begin
        // Close the gap from the removed position on.
        if (idx_ext >= cmd_i.pos) begin
          val_d = right_val_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

[sv/descending_sorted_list_core.sv]
`timescale 1ns / 1ps
// Top level of the descending sorted list: control, cell chain, output register.
// Depends on dsl_pkg, dsl_cell and assert_macros.svh.
//
// Keeps up to DEPTH signed 32-bit entries in descending order in a chain of
// cells, one entry per cell. Every beat carries one operation (insert, remove
// at position, read at position, or no operation) and yields exactly one
// result beat. All cells compare against the new value and shift in the same
// cycle: an item is accepted, the chain updates at that edge, and its result
// sits in the output register from the next cycle. A new beat is taken every
// cycle while the output register is empty or being drained. The read path is
// a one-hot select across the cells on the position. No clearing pass is run
// after reset; the entry count alone marks which cells hold data.
module descending_sorted_list_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [dsl_pkg::OP_W-1:0]       operation_i,
  input  logic signed [dsl_pkg::DATA_W-1:0] new_value_i,
  input  logic [dsl_pkg::POS_W-1:0]      position_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [dsl_pkg::STATUS_W-1:0]   status_o,
  output logic signed [dsl_pkg::DATA_W-1:0] value_out_o,
  output logic [dsl_pkg::ENTRY_W-1:0]    entry_total_o,
  output logic                           is_full_o,
  output logic                           is_empty_o
);
  import dsl_pkg::*;

  `include "assert_macros.svh"

  logic      in_acc;
  logic      out_valid_q;
  count_t    count_q;
  count_t    count_d;
  status_e   status_d;
  word_t     value_d;
  word_t     rd_val;
  cell_op_e  cell_op;
  cmp_t      pos_ext;
  cmp_t      cnt_ext;
  cell_cmd_t cmd;

  status_e   status_q;
  word_t     value_q;
  logic [ENTRY_W-1:0] total_q;
  logic      full_q;
  logic      empty_q;

  word_t             cell_val [DEPTH];
  logic [DEPTH-1:0]  cell_ge;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pos_ext    = cmp_t'(position_i);
  assign cnt_ext    = cmp_t'(count_q);

  // One-hot select of the addressed cell.
  always_comb begin
    rd_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (pos_ext == cmp_t'(i)) begin
        rd_val = rd_val | cell_val[i];
      end
    end
  end

  always_comb begin
    status_d = ST_OK;
    value_d  = '0;
    count_d  = count_q;
    cell_op  = CELL_HOLD;
    case (op_e'(operation_i))
      OP_INSERT: begin
        if (count_q >= CNT_W'(DEPTH)) begin
          status_d = ST_FULL;
        end else if (pos_ext > cnt_ext) begin
          status_d = ST_BAD_INDEX;
        end else begin
          cell_op = CELL_INSERT;
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_REMOVE, OP_READ: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status_d = ST_BAD_INDEX;
        end else begin
          value_d = rd_val;
          if (op_e'(operation_i) == OP_REMOVE) begin
            cell_op = CELL_REMOVE;
            count_d = count_q - CNT_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    cmd.op    = in_acc ? cell_op : CELL_HOLD;
    cmd.value = new_value_i;
    cmd.pos   = pos_ext;
    cmd.count = count_q;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    word_t left_val;
    logic  left_ge;
    word_t right_val;

    if (g == 0) begin : g_head
      // Nothing ranks ahead of the head cell.
      assign left_val = new_value_i;
      assign left_ge  = 1'b1;
    end else begin : g_body
      assign left_val = cell_val[g-1];
      assign left_ge  = cell_ge[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_val = cell_val[g];
    end else begin : g_inner
      assign right_val = cell_val[g+1];
    end

    dsl_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .idx_i       (IDX_W'(g)),
      .left_val_i  (left_val),
      .left_ge_i   (left_ge),
      .right_val_i (right_val),
      .val_o       (cell_val[g]),
      .ge_o        (cell_ge[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: load on every accepted beat, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      status_q <= status_d;
      value_q  <= value_d;
      total_q  <= ENTRY_W'(count_d);
      full_q   <= (count_d == CNT_W'(DEPTH));
      empty_q  <= (count_d == '0);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign value_out_o   = value_q;
  assign entry_total_o = total_q;
  assign is_full_o     = full_q;
  assign is_empty_o    = empty_q;

  `ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(DEPTH), "entry count above depth")
  `ASSERT_NEXT(a_insert_grows, in_acc && (cell_op == CELL_INSERT), count_q == $past(count_q) + CNT_W'(1), "insert did not grow count")
  `ASSERT_NEXT(a_remove_shrinks, in_acc && (cell_op == CELL_REMOVE), count_q == $past(count_q) - CNT_W'(1), "remove did not shrink count")
  `ASSERT_NEXT(a_result_total, in_acc, out_valid_q && (total_q == ENTRY_W'(count_q)), "result total differs from count")

  for (genvar g = 0; g < DEPTH - 1; g++) begin : g_order_chk
    `ASSERT_ALWAYS(a_sorted, (cmp_t'(g + 1) < cnt_ext) |-> (cell_val[g] >= cell_val[g+1]), "entries out of order")
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for descending_sorted_list_core: random and directed beats
// with idle gaps on the input side and stalls on the output side. Depends on dsl_pkg.

module testbench;
  import dsl_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_BEATS = 400;
  localparam int unsigned DRAIN_CYCLES = 10;

  typedef struct {
    status_e             status;
    word_t               value;
    logic [ENTRY_W-1:0]  total;
    logic                full;
    logic                empty;
  } list_result_t;

  // Shadow copy of the list plus the queue of results still owed by the block.
  class sorted_list_scoreboard;
    word_t        shadow_list[DEPTH];
    int unsigned  shadow_count;
    list_result_t owed_results[$];
    int unsigned  fail_count;

    function new();
      shadow_count = 0;
      fail_count   = 0;
    endfunction

    function int unsigned stored_count();
      return shadow_count;
    endfunction

    function int unsigned owed();
      return owed_results.size();
    endfunction

    // Apply one accepted operation to the shadow list and queue its result.
    function void note_beat(op_e op, word_t value, logic [POS_W-1:0] pos);
      list_result_t r;
      int unsigned  k;
      r.status = ST_OK;
      r.value  = '0;
      case (op)
        OP_INSERT: begin
          if (shadow_count >= DEPTH) begin
            r.status = ST_FULL;
          end else if (pos > shadow_count) begin
            r.status = ST_BAD_INDEX;
          end else begin
            // Equal values go after the ones already held.
            k = 0;
            while (k < shadow_count && shadow_list[k] >= value) k++;
            for (int unsigned i = shadow_count; i > k; i--) shadow_list[i] = shadow_list[i-1];
            shadow_list[k] = value;
            shadow_count++;
          end
        end
        OP_REMOVE, OP_READ: begin
          if (shadow_count == 0) begin
            r.status = ST_EMPTY;
          end else if (pos >= shadow_count) begin
            r.status = ST_BAD_INDEX;
          end else begin
            r.value = shadow_list[pos];
            if (op == OP_REMOVE) begin
              for (int unsigned i = pos; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
              shadow_count--;
            end
          end
        end
        default: ;
      endcase
      r.total = shadow_count[ENTRY_W-1:0];
      r.full  = (shadow_count == DEPTH);
      r.empty = (shadow_count == 0);
      owed_results.push_back(r);
    endfunction

    function void check_beat(logic [STATUS_W-1:0] status, word_t value,
                             logic [ENTRY_W-1:0] total, logic full, logic empty);
      list_result_t e;
      if (owed_results.size() == 0) begin
        $error("result beat with no operation pending");
        fail_count++;
        return;
      end
      e = owed_results.pop_front();
      if (status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, status);
        fail_count++;
      end
      if (value !== e.value) begin
        $error("value_out: expected %0d, actual %0d", e.value, value);
        fail_count++;
      end
      if (total !== e.total) begin
        $error("entry_total: expected %0d, actual %0d", e.total, total);
        fail_count++;
      end
      if (full !== e.full) begin
        $error("is_full: expected %0b, actual %0b", e.full, full);
        fail_count++;
      end
      if (empty !== e.empty) begin
        $error("is_empty: expected %0b, actual %0b", e.empty, empty);
        fail_count++;
      end
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [OP_W-1:0]         operation_i;
  logic signed [DATA_W-1:0] new_value_i;
  logic [POS_W-1:0]        position_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [STATUS_W-1:0]     status_o;
  logic signed [DATA_W-1:0] value_out_o;
  logic [ENTRY_W-1:0]      entry_total_o;
  logic                    is_full_o;
  logic                    is_empty_o;

  sorted_list_scoreboard sb;
  bit                    no_gaps;

  descending_sorted_list_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .new_value_i   (new_value_i),
    .position_i    (position_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .value_out_o   (value_out_o),
    .entry_total_o (entry_total_o),
    .is_full_o     (is_full_o),
    .is_empty_o    (is_empty_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic word_t pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return word_t'($urandom);
    // Narrow range to produce plenty of equal values.
    if (r < 70) return word_t'(int'($urandom_range(0, 15)) - 8);
    if (r < 85) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7FFF_FFFF;
        1: return 32'sh8000_0000;
        2: return '0;
        default: return -32'sd1;
      endcase
    end
    return word_t'({1'b1, 31'($urandom)});
  endfunction

  task automatic send_beat(op_e op, word_t value, logic [POS_W-1:0] pos);
    int unsigned gap;
    gap = no_gaps ? 0 : idle_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    operation_i = op;
    new_value_i = value;
    position_i  = pos;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    sb.note_beat(op, value, pos);
  endtask

  task automatic run_directed();
    send_beat(OP_READ, 32'sd5, 5'd0);           // read on empty list
    send_beat(OP_REMOVE, 32'sd5, 5'd0);         // remove on empty list
    send_beat(OP_NOP, 32'sh7FFF_FFFF, 5'd31);   // no operation
    send_beat(OP_INSERT, 32'sd9, 5'd1);         // position above the total
    send_beat(OP_INSERT, 32'sh7FFF_FFFF, 5'd0);
    send_beat(OP_INSERT, 32'sh8000_0000, 5'd1);
    send_beat(OP_INSERT, 32'sd0, 5'd0);         // position only checked
    send_beat(OP_INSERT, 32'sd0, 5'd3);         // equal value
    send_beat(OP_READ, '0, 5'd31);
    send_beat(OP_READ, '0, 5'd4);               // position equal to the total
    send_beat(OP_READ, '0, 5'd3);
    send_beat(OP_REMOVE, '0, 5'd0);
    send_beat(OP_REMOVE, '0, 5'd2);
    send_beat(OP_INSERT, -32'sd1, 5'd31);
    while (sb.stored_count() < DEPTH) send_beat(OP_INSERT, pick_value(), 5'd0);
    send_beat(OP_INSERT, 32'sd1, 5'd0);         // insert into full list
    send_beat(OP_READ, '0, 5'(DEPTH - 1));
    send_beat(OP_READ, '0, 5'(DEPTH));
    send_beat(OP_REMOVE, '0, 5'(DEPTH - 1));
  endtask

  // Phases lean toward filling, draining or a mix so full and empty are both reached.
  task automatic run_random(int unsigned beats);
    int unsigned phase;
    int unsigned r;
    int unsigned cnt;
    int unsigned insert_pct;
    int unsigned remove_pct;
    op_e         op;
    logic [POS_W-1:0] pos;
    phase = 0;
    insert_pct = 50;
    remove_pct = 25;
    for (int unsigned n = 0; n < beats; n++) begin
      if (n % 40 == 0) begin
        phase = $urandom_range(0, 2);
        no_gaps = ($urandom_range(0, 3) == 0);
        insert_pct = (phase == 0) ? 75 : (phase == 1) ? 20 : 45;
        remove_pct = (phase == 0) ? 12 : (phase == 1) ? 60 : 30;
      end
      r = $urandom_range(0, 99);
      if (r < 3) op = OP_NOP;
      else if (r < 3 + insert_pct) op = OP_INSERT;
      else if (r < 3 + insert_pct + remove_pct) op = OP_REMOVE;
      else op = OP_READ;
      cnt = sb.stored_count();
      if ($urandom_range(0, 99) < 15) pos = 5'($urandom_range(0, 31));
      else if (op == OP_INSERT) pos = 5'($urandom_range(0, (cnt < DEPTH) ? cnt : DEPTH));
      else pos = (cnt > 0) ? 5'($urandom_range(0, cnt - 1)) : 5'd0;
      send_beat(op, pick_value(), pos);
    end
  endtask

  // Output stall: free runs broken by stalls of random length.
  initial begin
    int unsigned g;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      out_stall_i = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      g = idle_gap();
      if (g > 0) begin
        out_stall_i = 1'b1;
        repeat (g) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_beat(status_o, value_out_o, entry_total_o, is_full_o, is_empty_o);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("descending_sorted_list_core test failed");
    $finish;
  end

  initial begin
    sb          = new();
    no_gaps     = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    operation_i = OP_NOP;
    new_value_i = '0;
    position_i  = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    run_directed();
    run_random(RANDOM_BEATS);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.owed() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.fail_count == 0 && sb.owed() == 0) begin
      $display("descending_sorted_list_core test passed");
    end else begin
      $display("descending_sorted_list_core test failed");
    end
    $finish;
  end

endmodule
